/* src/thermostat_relay_with_led_scan_unit_defines.svh */
// Assertion macros shared by the thermostat relay and LED scan RTL.
`ifndef THERMOSTAT_RELAY_WITH_LED_SCAN_UNIT_DEFINES_SVH
`define THERMOSTAT_RELAY_WITH_LED_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/trs_pkg.sv */
// Types and constants of the thermostat relay and LED scan unit.
package trs_pkg;

    localparam int TEMP_W      = 11;
    localparam int SEG_W       = 8;
    localparam int DIGIT_W     = 3;
    localparam int CFG_INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;

    localparam logic [TEMP_W-1:0] LOW_THRESHOLD_RESET  = 11'd200;
    localparam logic [TEMP_W-1:0] HIGH_THRESHOLD_RESET = 11'd220;

    // Input word modes
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_READING = 1'b1;

    // Scan positions
    localparam logic [1:0] SCAN_HUNDREDS = 2'd0;
    localparam logic [1:0] SCAN_TENS     = 2'd1;
    localparam logic [1:0] SCAN_UNITS    = 2'd2;
    localparam logic [1:0] SCAN_STRAY    = 2'd3;

    localparam logic [SEG_W-1:0] DP_BIT = 8'h80;

    // Three decimal digits of the shown value modulo 1000
    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } bcd3_t;

    // Seven-segment pattern, segments a..g in bits 0..6
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

/* src/trs_digits.sv */
// Splits an 11-bit value modulo 1000 into three decimal digits.
module trs_digits
    import trs_pkg::*;
(
    input  logic [TEMP_W-1:0] value,
    output bcd3_t             digits
);

    logic [9:0]  mod_val;
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [6:0]  rem_val;
    logic [14:0] tens_prod;
    logic [3:0]  tens;

    // Value modulo 1000: value never reaches 3000
    always_comb
    begin
        if (value >= 11'd2000)
            mod_val = 10'(value - 11'd2000);
        else if (value >= 11'd1000)
            mod_val = 10'(value - 11'd1000);
        else
            mod_val = value[9:0];
    end

    // Divide by 100 as multiply by 41/4096, exact below 1000
    assign hund_prod = 16'(mod_val) * 16'd41;
    assign hund      = hund_prod[15:12];
    assign rem_val   = 7'(10'(mod_val) - 10'(hund) * 10'd100);

    // Divide by 10 as multiply by 205/2048, exact below 100
    assign tens_prod = 15'(rem_val) * 15'd205;
    assign tens      = tens_prod[14:11];

    always_comb
    begin
        digits.hundreds = hund;
        digits.tens     = tens;
        digits.units    = 4'(7'(rem_val) - 7'(tens) * 7'd10);
    end

endmodule

/* src/thermostat_relay_with_led_scan_unit.sv */
// Top level of the thermostat relay and LED scan unit.
//
// Input channel (in_valid/in_ready) carries one word: mode and reading.
// A reading word (mode 1) stores the value for display and updates the
// relay with hysteresis: on below low_threshold, off above high_threshold.
// A tick word (mode 0) drives one digit of the shown value modulo 1000
// (hundreds, tens with decimal point, units) and advances the scan.
// Every input word yields exactly one result word on out_valid/out_ready.
// Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is low_threshold, 1 is high_threshold, others ignored.
// The result is registered: it goes to the output register, or to the skid register while the receiver stalls.
// Throughput: one word per cycle while the skid register is empty; the digit decode and
// state update between the input handshake and the output register are combinational.
// When the receiver stalls, one more word is held in a skid register;
// in_ready drops only while that skid register is full.
// Reset: thresholds 200 and 220, scan position 0, shown value 0, relay
// off, output and skid registers empty.
`include "thermostat_relay_with_led_scan_unit_defines.svh"

module thermostat_relay_with_led_scan_unit
    import trs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [TEMP_W-1:0]      reading,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SEG_W-1:0]       segments,
    output logic [DIGIT_W-1:0]     digit_enable,
    output logic                   relay_on
);

    logic [TEMP_W-1:0]  low_thr_reg;
    logic [TEMP_W-1:0]  high_thr_reg;
    logic [1:0]         scan_pos_reg;
    logic [1:0]         scan_pos_next;
    logic [TEMP_W-1:0]  shown_reg;
    logic [TEMP_W-1:0]  shown_next;
    logic               relay_reg;
    logic               relay_next;

    logic               out_valid_reg;
    logic [SEG_W-1:0]   out_seg_reg;
    logic [DIGIT_W-1:0] out_en_reg;
    logic               out_relay_reg;
    logic               skid_valid_reg;
    logic [SEG_W-1:0]   skid_seg_reg;
    logic [DIGIT_W-1:0] skid_en_reg;
    logic               skid_relay_reg;

    logic               in_fire;
    logic               out_fire;
    bcd3_t              digits;
    logic [SEG_W-1:0]   res_seg;
    logic [DIGIT_W-1:0] res_en;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    trs_digits u_digits
    (
        .value  (shown_reg),
        .digits (digits)
    );

    // Per-word result and next state
    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        shown_next    = shown_reg;
        relay_next    = relay_reg;
        res_seg       = '0;
        res_en        = '0;
        if (mode == MODE_READING)
        begin
            shown_next = reading;
            if (reading < low_thr_reg)
                relay_next = 1'b1;
            else if (reading > high_thr_reg)
                relay_next = 1'b0;
        end
        else
        begin
            case (scan_pos_reg)
                SCAN_HUNDREDS:
                begin
                    res_seg = seg_pattern(digits.hundreds);
                    res_en  = 3'b001;
                end
                SCAN_TENS:
                begin
                    res_seg = seg_pattern(digits.tens) | DP_BIT;
                    res_en  = 3'b010;
                end
                SCAN_UNITS:
                begin
                    res_seg = seg_pattern(digits.units);
                    res_en  = 3'b100;
                end
                default:
                begin
                    res_seg = '0;
                    res_en  = '0;
                end
            endcase
            scan_pos_next = (scan_pos_reg >= SCAN_UNITS) ? SCAN_HUNDREDS
                                                         : 2'(scan_pos_reg + 2'd1);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THRESHOLD_RESET;
            high_thr_reg <= HIGH_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= SCAN_HUNDREDS;
            shown_reg    <= '0;
            relay_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            scan_pos_reg <= scan_pos_next;
            shown_reg    <= shown_next;
            relay_reg    <= relay_next;
        end
    end

    // Output register and skid stage: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Output register and skid stage: payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_seg_reg   <= res_seg;
                out_en_reg    <= res_en;
                out_relay_reg <= relay_next;
            end
            else
            begin
                skid_seg_reg   <= res_seg;
                skid_en_reg    <= res_en;
                skid_relay_reg <= relay_next;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_seg_reg   <= skid_seg_reg;
            out_en_reg    <= skid_en_reg;
            out_relay_reg <= skid_relay_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = out_seg_reg;
    assign digit_enable = out_en_reg;
    assign relay_on     = out_relay_reg;

    // Checks
    `TRS_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `TRS_ASSERT_NOW(a_no_stray_scan, 1'b1, scan_pos_reg != SCAN_STRAY)
    `TRS_ASSERT_NEXT(a_scan_wraps,
        in_fire && mode == MODE_TICK && scan_pos_reg == SCAN_UNITS,
        scan_pos_reg == SCAN_HUNDREDS)
    `TRS_ASSERT_NEXT(a_relay_on_low,
        in_fire && mode == MODE_READING && reading < low_thr_reg,
        relay_reg)
    `TRS_ASSERT_NEXT(a_skid_on_stall,
        in_fire && out_valid_reg && !out_ready,
        skid_valid_reg && !in_ready)

endmodule
